FILE: rtl/cobs_enc_pkg.sv
// Package for the COBS frame encoder: widths, code constants and the
// record passed from the item front end to the write sequencer.
// No dependencies.
package cobs_enc_pkg;

  localparam int unsigned OffW            = 11;
  localparam int unsigned ByteW           = 8;
  localparam int unsigned DefMaxFrameBytes = 1024;
  localparam int unsigned DefQueueDepth   = 2;

  localparam logic [ByteW-1:0] CodeStart = 8'h01;
  localparam logic [ByteW-1:0] CodeFull  = 8'hFF;

  localparam int unsigned PendW     = 3;
  localparam int unsigned PendData  = 0;
  localparam int unsigned PendClose = 1;
  localparam int unsigned PendEof   = 2;

  typedef struct packed {
    logic [PendW-1:0] pend;
    logic [OffW-1:0]  data_off;
    logic [ByteW-1:0] data_byte;
    logic [OffW-1:0]  close_off;
    logic [ByteW-1:0] close_code;
    logic [OffW-1:0]  eof_off;
    logic [ByteW-1:0] eof_code;
    logic [OffW-1:0]  frame_len;
    logic             overflow;
  } cobs_enc_rec_t;

endpackage

FILE: rtl/cobs_enc_front.sv
// Front end of the COBS frame encoder: accepts input items, keeps the
// running frame state and emits a write record for each item that causes a write.
// Depends on cobs_enc_pkg.
module cobs_enc_front
  import cobs_enc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = DefMaxFrameBytes
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             byte_present_i,
  input  logic             end_of_frame_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output cobs_enc_rec_t    q_rec_o
);

  localparam int unsigned TakenW = $clog2(MAX_FRAME_BYTES + 1);

  logic [ByteW-1:0]  block_count_q, block_count_d;
  logic [OffW-1:0]   code_slot_q, code_slot_d;
  logic [OffW-1:0]   next_offset_q, next_offset_d;
  logic [TakenW-1:0] bytes_taken_q, bytes_taken_d;
  logic              overflow_q, overflow_d;

  logic             accept;
  logic             take;
  logic             drop;
  logic             has_data;
  logic             has_close;
  logic             blk_full;
  logic [ByteW-1:0] cnt_inc;
  logic [ByteW-1:0] cnt1;
  logic [OffW-1:0]  next1;
  logic [OffW-1:0]  next2;
  logic [OffW-1:0]  slot1;
  logic             ovf1;

  always_comb begin
    accept    = push && !q_full_i;
    take      = byte_present_i && (bytes_taken_q < TakenW'(MAX_FRAME_BYTES));
    drop      = byte_present_i && !take;
    has_data  = take && (data_byte_i != '0);
    has_close = 1'b0;
    cnt_inc   = block_count_q + 1'b1;
    blk_full  = has_data && (cnt_inc == CodeFull);
    has_close = take && ((data_byte_i == '0) || blk_full);
    next1     = has_data ? next_offset_q + 1'b1 : next_offset_q;
    slot1     = has_close ? next1 : code_slot_q;
    next2     = has_close ? next1 + 1'b1 : next1;
    cnt1      = has_close ? CodeStart : (has_data ? cnt_inc : block_count_q);
    ovf1      = overflow_q || drop;

    q_rec_o.pend[PendData]  = has_data;
    q_rec_o.pend[PendClose] = has_close;
    q_rec_o.pend[PendEof]   = end_of_frame_i;
    q_rec_o.data_off   = next_offset_q;
    q_rec_o.data_byte  = data_byte_i;
    q_rec_o.close_off  = code_slot_q;
    q_rec_o.close_code = (data_byte_i == '0) ? block_count_q : CodeFull;
    q_rec_o.eof_off    = slot1;
    q_rec_o.eof_code   = cnt1;
    q_rec_o.frame_len  = slot1 + 1'b1;
    q_rec_o.overflow   = ovf1;
    q_push_o = accept && (has_data || has_close || end_of_frame_i);

    block_count_d = block_count_q;
    code_slot_d   = code_slot_q;
    next_offset_d = next_offset_q;
    bytes_taken_d = bytes_taken_q;
    overflow_d    = overflow_q;
    if (accept) begin
      if (end_of_frame_i) begin
        block_count_d = CodeStart;
        code_slot_d   = '0;
        next_offset_d = OffW'(1);
        bytes_taken_d = '0;
        overflow_d    = 1'b0;
      end else begin
        block_count_d = cnt1;
        code_slot_d   = slot1;
        next_offset_d = next2;
        bytes_taken_d = take ? bytes_taken_q + 1'b1 : bytes_taken_q;
        overflow_d    = ovf1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= CodeStart;
      code_slot_q   <= '0;
      next_offset_q <= OffW'(1);
      bytes_taken_q <= '0;
      overflow_q    <= 1'b0;
    end else begin
      block_count_q <= block_count_d;
      code_slot_q   <= code_slot_d;
      next_offset_q <= next_offset_d;
      bytes_taken_q <= bytes_taken_d;
      overflow_q    <= overflow_d;
    end
  end

`ifndef ASSERT_OFF
  a_count_below_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    block_count_q != CodeFull)
    else $error("block count left at full code");
`endif

endmodule

FILE: rtl/cobs_enc_queue.sv
// Short record queue between the encoder front end and write sequencer.
// Depends on cobs_enc_pkg.
module cobs_enc_queue
  import cobs_enc_pkg::*;
#(
  parameter int unsigned DEPTH = DefQueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cobs_enc_rec_t rec_i,
  output logic          full_o,
  input  logic          pop_i,
  output cobs_enc_rec_t rec_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cobs_enc_rec_t   mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    full_o  = (count_q == CntW'(DEPTH));
    empty_o = (count_q == '0);
    rec_o   = mem_q[rd_ptr_q];
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("record pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("record popped from empty queue");
`endif

endmodule

FILE: rtl/cobs_enc_back.sv
// COBS frame encoder write sequencer: turns each record into data, block-code
// and frame-end writes into an output register, one per cycle while pop is high.
// Depends on cobs_enc_pkg.
module cobs_enc_back
  import cobs_enc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cobs_enc_rec_t    q_rec_i,
  input  logic             q_empty_i,
  output logic             q_pop_o,
  output logic             empty,
  input  logic             pop,
  output logic [OffW-1:0]  write_offset_o,
  output logic [ByteW-1:0] write_byte_o,
  output logic             is_code_o,
  output logic             last_of_run_o,
  output logic [OffW-1:0]  frame_length_o,
  output logic             overflow_o
);

  cobs_enc_rec_t    rec_q, rec_d;
  logic [PendW-1:0] pend_q, pend_d;
  logic             out_valid_q, out_valid_d;
  logic [OffW-1:0]  offset_q, offset_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic             code_q, code_d;
  logic             last_q, last_d;
  logic [OffW-1:0]  flen_q, flen_d;
  logic             ovf_q, ovf_d;

  logic             adv;
  logic             load_out;
  logic [PendW-1:0] sel;
  logic [PendW-1:0] rest;

  always_comb begin
    adv      = !out_valid_q || pop;
    sel      = pend_q & (~pend_q + 1'b1);
    rest     = pend_q & ~sel;
    load_out = adv && (pend_q != '0);

    offset_d = rec_q.data_off;
    byte_d   = rec_q.data_byte;
    code_d   = 1'b0;
    flen_d   = '0;
    if (sel[PendClose]) begin
      offset_d = rec_q.close_off;
      byte_d   = rec_q.close_code;
      code_d   = 1'b1;
    end else if (sel[PendEof]) begin
      offset_d = rec_q.eof_off;
      byte_d   = rec_q.eof_code;
      code_d   = 1'b1;
      flen_d   = rec_q.frame_len;
    end
    last_d = (rest == '0);
    ovf_d  = rec_q.overflow;

    out_valid_d = out_valid_q && !pop;
    pend_d      = pend_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      pend_d      = rest;
    end
    q_pop_o = (pend_d == '0) && !q_empty_i;
    rec_d   = rec_q;
    if (q_pop_o) begin
      pend_d = q_rec_i.pend;
      rec_d  = q_rec_i;
    end

    empty          = !out_valid_q;
    write_offset_o = offset_q;
    write_byte_o   = byte_q;
    is_code_o      = code_q;
    last_of_run_o  = last_q;
    frame_length_o = flen_q;
    overflow_o     = ovf_q;
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
    if (load_out) begin
      offset_q <= offset_d;
      byte_q   <= byte_d;
      code_q   <= code_d;
      last_q   <= last_d;
      flen_q   <= flen_d;
      ovf_q    <= ovf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef ASSERT_OFF
  a_data_no_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !code_q) |-> (flen_q == '0))
    else $error("frame length on a data write");
  a_length_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (flen_q != '0)) |-> (code_q && last_q))
    else $error("frame length on a write that does not close the item");
`endif

endmodule

FILE: rtl/cobs_frame_encoder_core.sv
// COBS frame encoder, top level: front end, record queue and write sequencer.
// Depends on cobs_enc_pkg, cobs_enc_front, cobs_enc_queue, cobs_enc_back.
//
// Input channel: an item (data_byte_i, byte_present_i, end_of_frame_i) is
// taken on a clock edge with push high and full low. Output channel: the
// oldest buffer write (write_offset_o, write_byte_o, is_code_o,
// last_of_run_o, frame_length_o, overflow_o) is shown while empty is low and
// leaves on an edge with pop high. An item causes zero to three writes:
// a data write, a block code write and, on end_of_frame_i, the closing code
// write that carries the frame length. last_of_run_o marks an item's last write.
// An item's first write passes the queue, rec_q and the output register.
// Throughput: the sequencer puts out one write per cycle while pop is high, and
// a non-final data byte causes two writes at most; the front end takes an item
// per cycle while the QUEUE_DEPTH-entry queue has room.
// Reset clears the frame state, the queue and the output register.
// When the receiver holds pop low, the output register holds its write, the
// queue fills and full rises; no item or write is dropped.
module cobs_frame_encoder_core
  import cobs_enc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = DefMaxFrameBytes,
  parameter int unsigned QUEUE_DEPTH     = DefQueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             byte_present_i,
  input  logic             end_of_frame_i,
  output logic             empty,
  input  logic             pop,
  output logic [OffW-1:0]  write_offset_o,
  output logic [ByteW-1:0] write_byte_o,
  output logic             is_code_o,
  output logic             last_of_run_o,
  output logic [OffW-1:0]  frame_length_o,
  output logic             overflow_o
);

  cobs_enc_rec_t front_rec;
  cobs_enc_rec_t back_rec;
  logic          front_push;
  logic          q_full;
  logic          q_empty;
  logic          back_pop;

  assign full = q_full;

  cobs_enc_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .data_byte_i    (data_byte_i),
    .byte_present_i (byte_present_i),
    .end_of_frame_i (end_of_frame_i),
    .q_full_i       (q_full),
    .q_push_o       (front_push),
    .q_rec_o        (front_rec)
  );

  cobs_enc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .rec_i   (front_rec),
    .full_o  (q_full),
    .pop_i   (back_pop),
    .rec_o   (back_rec),
    .empty_o (q_empty)
  );

  cobs_enc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_rec_i        (back_rec),
    .q_empty_i      (q_empty),
    .q_pop_o        (back_pop),
    .empty          (empty),
    .pop            (pop),
    .write_offset_o (write_offset_o),
    .write_byte_o   (write_byte_o),
    .is_code_o      (is_code_o),
    .last_of_run_o  (last_of_run_o),
    .frame_length_o (frame_length_o),
    .overflow_o     (overflow_o)
  );

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for cobs_frame_encoder_core: drives frames through the push/full
// side, predicts each buffer write in a scoreboard class and checks every popped write.
// Depends on cobs_enc_pkg and the encoder RTL.
module testbench;
  import cobs_enc_pkg::*;

  localparam int unsigned MaxFrame  = DefMaxFrameBytes;
  localparam int          RandItems = 60;
  localparam int          CalmItems = 20;
  localparam int          Limit     = 400000;

  typedef struct packed {
    logic [OffW-1:0]  offset;
    logic [ByteW-1:0] wbyte;
    logic             code;
    logic             last;
    logic [OffW-1:0]  flen;
    logic             ovf;
  } buf_write_t;

  class frame_write_board;
    buf_write_t  pending_writes[$];
    buf_write_t  run[$];
    int unsigned max_bytes;
    int unsigned blk_count, slot, next_off, taken;
    bit          ovf_seen;
    int          errors, writes_seen, frames, ovf_frames;

    function new(int unsigned limit_bytes);
      max_bytes = limit_bytes;
      clear_frame();
    endfunction

    function void clear_frame();
      blk_count = CodeStart;
      slot      = 0;
      next_off  = 1;
      taken     = 0;
      ovf_seen  = 1'b0;
    endfunction

    function void add_write(int unsigned off, int unsigned val, bit code, int unsigned flen);
      buf_write_t w;
      w.offset = off[OffW-1:0];
      w.wbyte  = val[ByteW-1:0];
      w.code   = code;
      w.last   = 1'b0;
      w.flen   = flen[OffW-1:0];
      w.ovf    = ovf_seen;
      run.push_back(w);
    endfunction

    function void close_block();
      add_write(slot, blk_count, 1'b1, 0);
      slot      = next_off;
      next_off  = (next_off + 1) & 32'h1FFFF;
      blk_count = CodeStart;
    endfunction

    function void take_item(logic [ByteW-1:0] din, logic present, logic eof);
      buf_write_t w;
      run.delete();
      if (present) begin
        if (taken >= max_bytes) begin
          ovf_seen = 1'b1;
        end else begin
          taken++;
          if (din == 0) begin
            close_block();
          end else begin
            add_write(next_off, din, 1'b0, 0);
            next_off = (next_off + 1) & 32'h1FFFF;
            blk_count++;
            if (blk_count == CodeFull) close_block();
          end
        end
      end
      if (eof) begin
        frames++;
        if (ovf_seen) ovf_frames++;
        add_write(slot, blk_count, 1'b1, slot + 1);
        clear_frame();
      end
      foreach (run[k]) begin
        w      = run[k];
        w.last = (k == run.size() - 1);
        pending_writes.push_back(w);
      end
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void match_write(buf_write_t got);
      buf_write_t want;
      writes_seen++;
      if (pending_writes.size() == 0) begin
        $error("unexpected write: offset %0d byte %0d", got.offset, got.wbyte);
        errors++;
        return;
      end
      want = pending_writes.pop_front();
      check_field("write_offset", 16'(want.offset), 16'(got.offset));
      check_field("write_byte", 16'(want.wbyte), 16'(got.wbyte));
      check_field("is_code", 16'(want.code), 16'(got.code));
      check_field("last_of_run", 16'(want.last), 16'(got.last));
      check_field("frame_length", 16'(want.flen), 16'(got.flen));
      check_field("overflow", 16'(want.ovf), 16'(got.ovf));
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             push;
  logic             full;
  logic [ByteW-1:0] data_byte_i;
  logic             byte_present_i;
  logic             end_of_frame_i;
  logic             empty;
  logic             pop;
  logic [OffW-1:0]  write_offset_o;
  logic [ByteW-1:0] write_byte_o;
  logic             is_code_o;
  logic             last_of_run_o;
  logic [OffW-1:0]  frame_length_o;
  logic             overflow_o;

  frame_write_board board;
  buf_write_t       got_write;
  bit               calm;
  int               stall_left;
  int               cycles;
  int               items_sent;

  cobs_frame_encoder_core #(
    .MAX_FRAME_BYTES(MaxFrame)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .byte_present_i (byte_present_i),
    .end_of_frame_i (end_of_frame_i),
    .empty          (empty),
    .pop            (pop),
    .write_offset_o (write_offset_o),
    .write_byte_o   (write_byte_o),
    .is_code_o      (is_code_o),
    .last_of_run_o  (last_of_run_o),
    .frame_length_o (frame_length_o),
    .overflow_o     (overflow_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == Limit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        got_write.offset = write_offset_o;
        got_write.wbyte  = write_byte_o;
        got_write.code   = is_code_o;
        got_write.last   = last_of_run_o;
        got_write.flen   = frame_length_o;
        got_write.ovf    = overflow_o;
        board.match_write(got_write);
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic logic [ByteW-1:0] pick_byte(int zero_pct);
    if ($urandom_range(0, 99) < zero_pct) return 8'h00;
    case ($urandom_range(0, 7))
      0:       return 8'hFF;
      1:       return 8'h01;
      default: return ByteW'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic send_item(input logic [ByteW-1:0] din, input logic present, input logic eof);
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    push           <= 1'b1;
    data_byte_i    <= din;
    byte_present_i <= present;
    end_of_frame_i <= eof;
    do @(posedge clk_i); while (full);
    board.take_item(din, present, eof);
    if (present || eof) items_sent++;
  endtask

  task automatic send_frame(input int len, input int zero_pct);
    bit tail_empty;
    tail_empty = (len == 0) || ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(ByteW'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(pick_byte(zero_pct), 1'b1, !tail_empty && (i == len - 1));
    end
    if (tail_empty) send_item(ByteW'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic drain_writes();
    push <= 1'b0;
    while (board.pending_writes.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    int rand_start;
    int k;
    board          = new(MaxFrame);
    rst_ni         = 1'b0;
    push           = 1'b0;
    pop            = 1'b0;
    data_byte_i    = '0;
    byte_present_i = 1'b0;
    end_of_frame_i = 1'b0;
    calm           = 1'b0;
    stall_left     = 0;
    cycles         = 0;
    items_sent     = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty frame, ignored items, single bytes at the extremes, a two-byte frame
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h01, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b1);
    // zeros back to back, closed by an empty end item
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    // mixed data with a zero in the middle, then a frame of two zeros
    send_item(8'h55, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hAA, 1'b1, 1'b0);
    send_item(8'hFE, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);

    // full last block, then a short zero-heavy frame
    send_frame(254, 0);
    send_frame(3, 30);
    drain_writes();

    rand_start = items_sent;
    while (items_sent - rand_start < RandItems) begin
      calm = (items_sent - rand_start) >= RandItems - CalmItems;
      k = $urandom_range(0, 19);
      if (k < 14)       send_frame($urandom_range(0, 16), 15);
      else if (k < 18)  send_frame($urandom_range(17, 60), 8);
      else if (k == 18) send_frame($urandom_range(0, 6), 70);
      else              send_item(ByteW'($urandom_range(0, 255)), 1'b0, 1'b0);
    end
    calm = 1'b1;

    drain_writes();
    repeat (12) @(posedge clk_i);
    if (board.pending_writes.size() > 0) begin
      $error("%0d expected writes never arrived", board.pending_writes.size());
      board.errors++;
    end
    $display("run covered %0d items in %0d frames, %0d of them past the byte limit",
             items_sent, board.frames, board.ovf_frames);
    $display("%0d buffer writes checked field by field, %0d mismatches",
             board.writes_seen, board.errors);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: cobs_frame_encoder_core.f
rtl/cobs_enc_pkg.sv
rtl/cobs_enc_front.sv
rtl/cobs_enc_queue.sv
rtl/cobs_enc_back.sv
rtl/cobs_frame_encoder_core.sv
tb/sv/testbench.sv
